// ===== sv/s5rp_pkg.sv =====
// Package with the constants and types shared by the SOCKS5 reply parser and its checker.
`timescale 1ns / 1ps
`default_nettype none
package s5rp_pkg;

  localparam logic [7:0] SocksVersion = 8'h05;
  localparam logic [7:0] AtypIpv4     = 8'h01;
  localparam logic [7:0] AtypDomain   = 8'h03;
  localparam logic [7:0] AtypIpv6     = 8'h04;
  localparam logic [7:0] LenIpv4      = 8'd4;
  localparam logic [7:0] LenIpv6      = 8'd16;

  // Fixed part of a reply: four header bytes and two port bytes.
  localparam logic [9:0] FixedLen     = 10'd6;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_HDR  = 2'd1,
    STATUS_BAD_ATYP = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ===== sv/socks5_reply_parser.sv =====
// SOCKS5 server reply parser taking one received byte per word.
//
// The input channel (in_valid_i, in_ready_o, rx_byte_i) carries the reply
// bytes in arrival order. The output channel (out_valid_o, out_ready_i and
// the result fields) carries one word per reply: the status, the address
// type byte and, for a good IPv4 reply, the bound address and port.
// A word appears in the cycle after the last byte of a reply is accepted, or
// in the cycle after the byte following an unknown address type. Parsing
// state and the result register are separate, so one byte is accepted in
// every cycle, and the input is only held off while a finished word waits
// in the result register and the receiver does not take it in that cycle.
// A stalled receiver therefore stops the input after at most one more
// reply has completed. Reset clears the byte count and the header flags,
// so the first byte afterwards is read as the version byte of a new reply,
// and empties the result register. After each reply the parser rearms in
// the same way without any idle cycle.
`timescale 1ns / 1ps
`default_nettype none
module socks5_reply_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       addr_type_o,
  output logic [31:0]      bound_ipv4_o,
  output logic [15:0]      bound_port_o
);

  logic [8:0]  count_q, count_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  out_type_q;
  logic [31:0] ipv4_q, ipv4_d;
  logic [15:0] bport_q, bport_d;

  logic        accept;
  logic        emit;
  logic        bad_atyp;
  logic        done;
  logic [8:0]  count_inc;
  logic [9:0]  total;
  logic        give_addr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hdr_ok_d  = hdr_ok_q;
    type_d    = type_q;
    len_d     = len_q;
    addr_d    = addr_q;
    bad_atyp  = 1'b0;
    if (count_q == 9'd0 && rx_byte_i != s5rp_pkg::SocksVersion) begin
      hdr_ok_d = 1'b0;
    end
    if (count_q == 9'd1 && rx_byte_i != 8'd0) begin
      hdr_ok_d = 1'b0;
    end
    if (count_q == 9'd3) begin
      type_d = rx_byte_i;
    end
    if (count_q == 9'd4) begin
      if (type_q == s5rp_pkg::AtypIpv4) begin
        len_d = s5rp_pkg::LenIpv4;
      end else if (type_q == s5rp_pkg::AtypDomain) begin
        len_d = rx_byte_i;
      end else if (type_q == s5rp_pkg::AtypIpv6) begin
        len_d = s5rp_pkg::LenIpv6;
      end else begin
        bad_atyp = 1'b1;
      end
    end
    if (count_q >= 9'd4 && count_q < 9'd8) begin
      addr_d = {addr_q[23:0], rx_byte_i};
    end
    port_d    = {port_q[7:0], rx_byte_i};
    count_inc = count_q + 9'd1;
    // The domain length byte itself belongs to the address field.
    total     = s5rp_pkg::FixedLen + {2'b00, len_d}
              + {9'd0, (type_d == s5rp_pkg::AtypDomain)};
    done      = (count_inc >= 9'd5) && ({1'b0, count_inc} >= total);
    emit      = bad_atyp || done;
    give_addr = hdr_ok_d && (type_d == s5rp_pkg::AtypIpv4);
    count_d   = emit ? 9'd0 : count_inc;
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = s5rp_pkg::STATUS_OK;
    ipv4_d      = 32'd0;
    bport_d     = 16'd0;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end
    if (bad_atyp) begin
      status_d = s5rp_pkg::STATUS_BAD_ATYP;
    end else if (!hdr_ok_d) begin
      status_d = s5rp_pkg::STATUS_BAD_HDR;
    end else begin
      status_d = s5rp_pkg::STATUS_OK;
    end
    if (!bad_atyp && give_addr) begin
      ipv4_d  = addr_d;
      bport_d = port_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 9'd0;
      type_q      <= 8'd0;
      len_q       <= 8'd0;
      hdr_ok_q    <= 1'b1;
      addr_q      <= 32'd0;
      port_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (emit) begin
          count_q  <= 9'd0;
          type_q   <= 8'd0;
          len_q    <= 8'd0;
          hdr_ok_q <= 1'b1;
          addr_q   <= 32'd0;
          port_q   <= 16'd0;
        end else begin
          count_q  <= count_d;
          type_q   <= type_d;
          len_q    <= len_d;
          hdr_ok_q <= hdr_ok_d;
          addr_q   <= addr_d;
          port_q   <= port_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q   <= status_d;
      out_type_q <= type_d;
      ipv4_q     <= ipv4_d;
      bport_q    <= bport_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign addr_type_o  = out_type_q;
  assign bound_ipv4_o = ipv4_q;
  assign bound_port_o = bport_q;

endmodule
`default_nettype wire

// ===== sv/s5rp_checker.sv =====
// Port-level assertions for the SOCKS5 reply parser and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module s5rp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  addr_type_o,
  input wire logic [31:0] bound_ipv4_o,
  input wire logic [15:0] bound_port_o
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(bound_ipv4_o) && $stable(bound_port_o) && $stable(addr_type_o))
    else $error("stalled result word changed");

  // Input is only held off while a result word waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == s5rp_pkg::STATUS_OK || status_o == s5rp_pkg::STATUS_BAD_HDR
      || status_o == s5rp_pkg::STATUS_BAD_ATYP)
    else $error("undefined status code");

  // Address and port are only given for a good IPv4 reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != s5rp_pkg::STATUS_OK || addr_type_o != s5rp_pkg::AtypIpv4)
      |-> bound_ipv4_o == 32'd0 && bound_port_o == 16'd0)
    else $error("bound address given for a reply that is not good IPv4");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == s5rp_pkg::STATUS_BAD_ATYP
      |-> addr_type_o != s5rp_pkg::AtypIpv4 && addr_type_o != s5rp_pkg::AtypDomain
        && addr_type_o != s5rp_pkg::AtypIpv6)
    else $error("known address type reported as unknown");

endmodule

bind socks5_reply_parser s5rp_checker u_s5rp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .rx_byte_i    (rx_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .addr_type_o  (addr_type_o),
  .bound_ipv4_o (bound_ipv4_o),
  .bound_port_o (bound_port_o)
);
`default_nettype wire
